>>> hw/rtl/variable_length_code_bit_packer_top_assert.svh
// Assertion macros shared by the packer's checker.
// No dependencies. Each macro expands to one labeled concurrent assertion.
`ifndef VARIABLE_LENGTH_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define VARIABLE_LENGTH_CODE_BIT_PACKER_TOP_ASSERT_SVH

// Checked on the rising edge, ignored while reset is asserted.
`define VLCBP_ASSERT_RST(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define VLCBP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> hw/rtl/vlcbp_pkg.sv
// Types and constants for the variable-length code bit packer.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package vlcbp_pkg;

	localparam int MAX_CODE_BITS = 32;
	localparam int CODE_W        = 32;
	// effective length limit: the smaller of the code limit and the field width
	localparam int CODE_LIM = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
	localparam int BYTE_W   = 8;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] code_bits;
		logic [5:0]  code_len;
	} vlcbp_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} vlcbp_out_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} vlcbp_state_t;

endpackage

>>> hw/rtl/variable_length_code_bit_packer_top.sv
// Top level of the LSB-first variable-length code bit packer.
// Depends on vlcbp_pkg.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready  | in_data  (op, code_bits, len)
//  out     | output    | out_valid / out_ready| out_data (out_byte, last)
//
// An append is loaded, then takes one step per 8-bit digit of the code
// (ceil(len/8), one step for a zero length, at most four); the byte-wide
// digit shifter sets this. A flush is loaded, then emits any pending bits as a last byte.
// Each digit step waits while the output register holds an untaken byte.
// in_ready is high only between items. Reset clears pending bits and control.

module variable_length_code_bit_packer_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  vlcbp_pkg::vlcbp_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output vlcbp_pkg::vlcbp_out_t  out_data
);
	import vlcbp_pkg::*;

	vlcbp_state_t state_q;
	logic [31:0]  code_q;
	logic [5:0]   rem_q;
	logic [6:0]   pend_q;
	logic [2:0]   pcnt_q;
	logic         out_valid_q;
	vlcbp_out_t   out_q;

	logic         in_acc;
	logic         slot_free;
	logic         step_go;
	logic         flush_go;
	logic         set_valid;
	logic [5:0]   eff_len;
	logic [3:0]   take;
	logic [7:0]   dmask;
	logic [7:0]   digit;
	logic [14:0]  acc;
	logic [3:0]   total;
	logic         emit;
	logic [2:0]   pcnt_next;
	logic [6:0]   pend_next;
	logic [5:0]   rem_next;
	logic         last_byte;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign step_go   = (state_q == ST_RUN) && slot_free;
	assign flush_go  = (state_q == ST_FLUSH) && slot_free;
	assign set_valid = (step_go && emit) || (flush_go && (pcnt_q != 3'd0));

	assign eff_len = (in_data.code_len > 6'(CODE_LIM)) ? 6'(CODE_LIM) : in_data.code_len;

	// one byte digit of the code per step, merged behind the pending bits
	always_comb begin
		take      = (rem_q >= 6'(BYTE_W)) ? 4'(BYTE_W) : rem_q[3:0];
		dmask     = 8'((9'd1 << take) - 9'd1);
		digit     = code_q[7:0] & dmask;
		acc       = {8'd0, pend_q} | (15'(digit) << pcnt_q);
		total     = {1'b0, pcnt_q} + take;
		emit      = total[3];
		pcnt_next = total[2:0];
		pend_next = emit ? acc[14:8] : acc[6:0];
		rem_next  = rem_q - 6'(take);
		last_byte = (rem_next + 6'(pcnt_next)) < 6'(BYTE_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			pend_q      <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (set_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rem_q   <= eff_len;
						state_q <= (in_data.op == OP_FLUSH) ? ST_FLUSH : ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_go) begin
						rem_q  <= rem_next;
						pend_q <= pend_next;
						pcnt_q <= pcnt_next;
						if (rem_next == 6'd0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						pend_q  <= '0;
						pcnt_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_q <= in_data.code_bits;
		end else if (step_go) begin
			code_q <= code_q >> BYTE_W;
		end
		if (step_go && emit) begin
			out_q.out_byte <= acc[7:0];
			out_q.last     <= last_byte;
		end else if (flush_go) begin
			out_q.out_byte <= {1'b0, pend_q};
			out_q.last     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/vlcbp_checker.sv
// Port-level checker for the packer, bound to its top level.
// Depends on vlcbp_pkg and variable_length_code_bit_packer_top_assert.svh.
`timescale 1ns / 1ps
`include "variable_length_code_bit_packer_top_assert.svh"

module vlcbp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input vlcbp_pkg::vlcbp_out_t out_data
);
	import vlcbp_pkg::*;

	`VLCBP_ASSERT_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "out_valid dropped before transaction")
	`VLCBP_ASSERT_RST(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_data), "out_data changed while stalled")
	// more bytes of the same item follow, so no new item may enter
	`VLCBP_ASSERT_RST(a_mid_item, clk, arst_n, out_valid && !out_data.last |-> !in_ready, "in_ready high mid item")
	`VLCBP_ASSERT_RST(a_one_item, clk, arst_n, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")
	// checked from the following edge: the first edge may see registers not yet reset
	`VLCBP_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !out_valid, "out_valid during reset")

endmodule

bind variable_length_code_bit_packer_top vlcbp_checker u_vlcbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> tb/tb.sv
// Self-checking testbench for the LSB-first variable-length code bit packer.
// Depends on vlcbp_pkg and variable_length_code_bit_packer_top; all bytes are
// predicted in the bench and checked in order against the output channel.
`timescale 1ns / 1ps

module tb;
	import vlcbp_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 120;
	localparam int DRAIN_CYCLES   = 12;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int MAX_REPORTS    = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	vlcbp_in_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	vlcbp_out_t out_data;

	// bench copy of the packer state
	logic [6:0] pend_bits;
	int         pend_cnt;
	vlcbp_out_t expected_bytes[$];

	int   send_idle_pct;
	int   stall_pct;
	logic hold_on = 1'b0;
	event start_hold;

	int err_count;
	int items_sent;
	int flushes_sent;
	int bytes_checked;
	int overlong_sent;

	variable_length_code_bit_packer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
		err_count++;
	endtask

	// Expected bytes for one accepted transaction; updates the bench state.
	task automatic pack_code(input vlcbp_in_t it);
		logic [63:0] acc;
		logic [63:0] code;
		int          len;
		int          total;
		int          nbytes;
		vlcbp_out_t  b;
		if (it.op == OP_FLUSH) begin
			if (pend_cnt != 0) begin
				b.out_byte = {1'b0, pend_bits};
				b.last     = 1'b1;
				expected_bytes.push_back(b);
			end
			pend_bits = '0;
			pend_cnt  = 0;
			return;
		end
		len = (int'(it.code_len) > CODE_LIM) ? CODE_LIM : int'(it.code_len);
		if (len == 0)
			return;
		code = {32'd0, it.code_bits};
		if (len < 32)
			code &= (64'd1 << len) - 64'd1;
		acc    = {57'd0, pend_bits} | (code << pend_cnt);
		total  = pend_cnt + len;
		nbytes = total / 8;
		for (int k = 0; k < nbytes; k++) begin
			b.out_byte = acc[8*k +: 8];
			b.last     = (k == nbytes - 1);
			expected_bytes.push_back(b);
		end
		acc       = acc >> (8 * nbytes);
		pend_cnt  = total % 8;
		pend_bits = acc[6:0] & ((7'd1 << pend_cnt) - 7'd1);
	endtask

	// Offers one transaction after a random gap; valid stays high afterwards
	// so back-to-back items never toggle it within one time step.
	task automatic send_item(input vlcbp_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		pack_code(it);
		items_sent++;
		if (it.op == OP_FLUSH)
			flushes_sent++;
		else if (it.code_len > CODE_LIM)
			overlong_sent++;
	endtask

	function automatic vlcbp_in_t make_item(logic op, logic [31:0] bits, int len);
		vlcbp_in_t it;
		it.op        = op;
		it.code_bits = bits;
		it.code_len  = len[5:0];
		return it;
	endfunction

	function automatic vlcbp_in_t random_item();
		int sel;
		vlcbp_in_t it;
		sel          = $urandom_range(99);
		it.op        = OP_APPEND;
		it.code_bits = $urandom();
		if (sel < 12) begin
			it.op       = OP_FLUSH;
			it.code_len = 6'($urandom_range(63));
		end else if (sel < 22)
			it.code_len = 6'($urandom_range(63, 33));
		else if (sel < 40)
			it.code_len = 6'($urandom_range(7, 0));
		else
			it.code_len = 6'($urandom_range(32, 0));
		return it;
	endfunction

	// Output side: random stalls, forced low during a hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
	end

	// Long receiver hold-off, counted here in clock cycles.
	initial begin
		forever begin
			@(start_hold);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	always @(posedge clk) begin
		vlcbp_out_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b",
					out_data.out_byte, out_data.last));
			end else begin
				exp_b = expected_bytes.pop_front();
				bytes_checked++;
				if (out_data.out_byte !== exp_b.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						out_data.out_byte, exp_b.out_byte));
				if (out_data.last !== exp_b.last)
					report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
						out_data.last, exp_b.last, exp_b.out_byte));
			end
		end
	end

	// Edge lengths, flush with and without pending bits, empty and overlong codes.
	task automatic test_directed_codes();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_item(make_item(OP_FLUSH,  32'h0000_0000, 0));
		send_item(make_item(OP_APPEND, 32'hDEAD_BEEF, 0));
		send_item(make_item(OP_APPEND, 32'hFFFF_FFFF, 32));
		send_item(make_item(OP_APPEND, 32'h0000_0001, 1));
		send_item(make_item(OP_APPEND, 32'h1234_5678, 0));
		send_item(make_item(OP_APPEND, 32'hA5A5_5A5A, 32));
		send_item(make_item(OP_APPEND, 32'h1234_5678, 63));
		send_item(make_item(OP_APPEND, 32'hFFFF_0000, 33));
		send_item(make_item(OP_APPEND, 32'hFFFF_FFFF, 7));
		send_item(make_item(OP_FLUSH,  32'hFFFF_FFFF, 63));
		send_item(make_item(OP_FLUSH,  32'h0000_0000, 0));
		send_item(make_item(OP_APPEND, 32'h0000_00C3, 8));
		send_item(make_item(OP_APPEND, 32'h0000_0000, 32));
		send_item(make_item(OP_APPEND, 32'h5555_5555, 40));
		send_item(make_item(OP_APPEND, 32'h0000_007F, 7));
		send_item(make_item(OP_APPEND, 32'hFFFF_FFFE, 1));
		send_item(make_item(OP_APPEND, 32'h0000_007F, 7));
		send_item(make_item(OP_FLUSH,  32'h0000_0000, 0));
		send_item(make_item(OP_APPEND, 32'h8000_0001, 31));
		send_item(make_item(OP_APPEND, 32'h0000_0003, 2));
		send_item(make_item(OP_APPEND, 32'hC0DE_0F0F, 16));
		send_item(make_item(OP_FLUSH,  32'h0000_0000, 0));
	endtask

	// Receiver stops for a long stretch while the sender keeps offering,
	// so the packer backs up and drops in_ready.
	task automatic test_fill_stall();
		send_idle_pct = 0;
		stall_pct     = 0;
		-> start_hold;
		for (int i = 0; i < 12; i++)
			send_item(make_item(OP_APPEND, $urandom(), $urandom_range(32, 24)));
		send_item(make_item(OP_FLUSH, 32'h0, 0));
	endtask

	task automatic run_random_phase(input int idle_pct, input int stall, input int n);
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		repeat (n) send_item(random_item());
	endtask

	// Random codes across the idle / stall mixes.
	task automatic test_random_traffic();
		run_random_phase(0, 0, 28);
		run_random_phase(51, 0, 28);
		run_random_phase(0, 51, 28);
		run_random_phase(20, 20, 28);
		send_item(make_item(OP_FLUSH, 32'h0, 0));
	endtask

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Timeout with %0d bytes outstanding", expected_bytes.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		pend_bits     = '0;
		pend_cnt      = 0;
		err_count     = 0;
		items_sent    = 0;
		flushes_sent  = 0;
		bytes_checked = 0;
		overlong_sent = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_codes();
		test_fill_stall();
		test_random_traffic();

		in_valid <= 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions (%0d flushes, %0d overlong codes), checked %0d bytes",
			items_sent, flushes_sent, overlong_sent, bytes_checked);
		$display("Covered: edge lengths, empty flush, long receiver hold-off, idle/stall mixes");
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> variable_length_code_bit_packer_top.f
+incdir+hw/rtl
hw/rtl/vlcbp_pkg.sv
hw/rtl/variable_length_code_bit_packer_top.sv
hw/rtl/vlcbp_checker.sv
tb/tb.sv
